// ===== src/pead_pkg.sv =====
// types, constants and helpers shared by the polygon sweep extension block
// no dependencies

package pead_pkg;

    localparam int MaxVertices = 256;
    localparam int IdxW        = $clog2(MaxVertices);
    localparam int CoordW      = 32;
    localparam int NormW       = 16;
    localparam int RangeW      = 8;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 32;
    localparam int ProdW       = CoordW + NormW;
    localparam int ShiftW      = CoordW + 3;
    localparam int SumW        = ShiftW + 1;
    localparam int FracShift   = 14;
    localparam int QueueDepth  = 4;
    localparam int QPtrW       = $clog2(QueueDepth);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIR_X           = 3'd0,
        CFG_DIR_Y           = 3'd1,
        CFG_MOVE_DISTANCE   = 3'd2,
        CFG_RANGE_FIRST     = 3'd3,
        CFG_RANGE_LAST      = 3'd4,
        CFG_FIRST_EDGE_FLAT = 3'd5,
        CFG_LAST_EDGE_FLAT  = 3'd6,
        CFG_NORMALS_PRESENT = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_KEEP  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_FIRST = 2'd2,
        KIND_LAST  = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic signed [NormW-1:0]  normal_x;
        logic signed [NormW-1:0]  normal_y;
        logic                     final_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic signed [NormW-1:0]  out_normal_x;
        logic signed [NormW-1:0]  out_normal_y;
        logic                     run_end;
        logic                     polygon_end;
    } t_out_item;

    typedef struct packed {
        logic signed [NormW-1:0]  dir_x;
        logic signed [NormW-1:0]  dir_y;
        logic signed [CoordW-1:0] move_distance;
        logic [RangeW-1:0]        range_first;
        logic [RangeW-1:0]        range_last;
        logic                     first_edge_flat;
        logic                     last_edge_flat;
        logic                     normals_present;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic signed [NormW-1:0]  normal_x;
        logic signed [NormW-1:0]  normal_y;
        logic                     final_vertex;
    } t_work;

    function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        hi = SumW'({1'b0, {(CoordW-1){1'b1}}});
        lo = -hi - SumW'(1);
        if (v > hi) begin
            return hi[CoordW-1:0];
        end else if (v < lo) begin
            return lo[CoordW-1:0];
        end
        return v[CoordW-1:0];
    endfunction

endpackage

// ===== src/polygon_extend_along_direction.sv =====
// top level of the polygon sweep extension block
// depends on pead_pkg, pead_cfg, pead_front, pead_queue, pead_back
//
// Vertices enter on i_valid/o_stall with i_data, in polygon order; final_vertex
// closes a polygon and restarts the vertex index. Results leave on
// o_valid/i_stall with o_data; run_end marks the last result of a vertex and
// polygon_end the last result of a polygon.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx; the user
// must write only while no transaction is in flight, as the block does not enforce it.
// The sweep offset settles through the product and offset registers after a write.
// A vertex accepted into the front register passes through the queue and shows
// its first result in the output register.
// Throughput: one vertex per cycle while the queue has room; the output register emits
// one result per cycle while the receiver does not stall, so the first and last vertices
// of the swept range, which give two results unless their edge is flat, hold their queue
// entry for both. The single offset multiplier per axis works on configuration only and
// does not limit the rate. Reset (synchronous, active low) restores register defaults,
// empties the queue and clears the vertex index. When the receiver stalls, the output
// holds, the four-entry queue and front register fill, then o_stall rises.

module polygon_extend_along_direction (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  pead_pkg::t_in_item              i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output pead_pkg::t_out_item             o_data,
    input  logic                            i_cfg_we,
    input  logic [pead_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [pead_pkg::CfgDataW-1:0]   i_cfg_data
);

    pead_pkg::t_cfg     w_cfg;
    pead_pkg::t_work    w_work;
    pead_pkg::t_work    w_head;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_head_valid;

    pead_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pead_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_cfg   (w_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_work  (w_work)
    );

    pead_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_work),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    pead_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule

// ===== src/pead_cfg.sv =====
// configuration register file for the polygon sweep extension block
// depends on pead_pkg

module pead_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pead_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [pead_pkg::CfgDataW-1:0]   i_cfg_data,
    output pead_pkg::t_cfg                  o_cfg
);

    pead_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_x           <= 16'sd16384;
            r_cfg.dir_y           <= '0;
            r_cfg.move_distance   <= '0;
            r_cfg.range_first     <= '0;
            r_cfg.range_last      <= '0;
            r_cfg.first_edge_flat <= 1'b0;
            r_cfg.last_edge_flat  <= 1'b0;
            r_cfg.normals_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (pead_pkg::t_cfg_reg'(i_cfg_idx))
                pead_pkg::CFG_DIR_X: begin
                    r_cfg.dir_x <= i_cfg_data[pead_pkg::NormW-1:0];
                end
                pead_pkg::CFG_DIR_Y: begin
                    r_cfg.dir_y <= i_cfg_data[pead_pkg::NormW-1:0];
                end
                pead_pkg::CFG_MOVE_DISTANCE: begin
                    r_cfg.move_distance <= i_cfg_data[pead_pkg::CoordW-1:0];
                end
                pead_pkg::CFG_RANGE_FIRST: begin
                    r_cfg.range_first <= i_cfg_data[pead_pkg::RangeW-1:0];
                end
                pead_pkg::CFG_RANGE_LAST: begin
                    r_cfg.range_last <= i_cfg_data[pead_pkg::RangeW-1:0];
                end
                pead_pkg::CFG_FIRST_EDGE_FLAT: begin
                    r_cfg.first_edge_flat <= i_cfg_data[0];
                end
                pead_pkg::CFG_LAST_EDGE_FLAT: begin
                    r_cfg.last_edge_flat <= i_cfg_data[0];
                end
                pead_pkg::CFG_NORMALS_PRESENT: begin
                    r_cfg.normals_present <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/pead_front.sv =====
// front stage: accepts vertices, tracks the vertex index and classifies each vertex
// depends on pead_pkg

module pead_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pead_pkg::t_in_item  i_data,
    input  pead_pkg::t_cfg      i_cfg,
    input  logic                i_full,
    output logic                o_push,
    output pead_pkg::t_work     o_work
);

    logic                       r_fv;
    pead_pkg::t_work            r_work;
    logic [pead_pkg::IdxW-1:0]  r_idx;
    logic [pead_pkg::IdxW-1:0]  n_idx;
    pead_pkg::t_kind            w_kind;
    logic                       w_accept;
    logic                       w_is_first;
    logic                       w_is_last;
    logic                       w_in_range;
    logic [31:0]                w_i;
    logic [31:0]                w_first;
    logic [31:0]                w_last;

    assign o_stall  = r_fv && i_full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_fv && !i_full;
    assign o_work   = r_work;

    always_comb begin
        w_i        = 32'(r_idx);
        w_first    = 32'(i_cfg.range_first);
        w_last     = 32'(i_cfg.range_last);
        w_is_first = (w_i == w_first) && !i_cfg.first_edge_flat;
        w_is_last  = (w_i == w_last) && !i_cfg.last_edge_flat;
        if (w_first > w_last) begin
            w_in_range = (w_i <= w_last) || (w_i >= w_first);
        end else begin
            w_in_range = (w_i >= w_first) && (w_i <= w_last);
        end
        if (w_is_first) begin
            w_kind = pead_pkg::KIND_FIRST;
        end else if (w_is_last) begin
            w_kind = pead_pkg::KIND_LAST;
        end else if (w_in_range) begin
            w_kind = pead_pkg::KIND_MOVE;
        end else begin
            w_kind = pead_pkg::KIND_KEEP;
        end
        // index wraps after the largest polygon
        if (i_data.final_vertex || (w_i == 32'(pead_pkg::MaxVertices - 1))) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + pead_pkg::IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv  <= 1'b0;
            r_idx <= '0;
        end else if (w_accept) begin
            r_fv  <= 1'b1;
            r_idx <= n_idx;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work.kind         <= w_kind;
            r_work.vertex_x     <= i_data.vertex_x;
            r_work.vertex_y     <= i_data.vertex_y;
            r_work.normal_x     <= i_data.normal_x;
            r_work.normal_y     <= i_data.normal_y;
            r_work.final_vertex <= i_data.final_vertex;
        end
    end

endmodule

// ===== src/pead_queue.sv =====
// small fifo of classified vertices between the front and back stages
// depends on pead_pkg

module pead_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pead_pkg::t_work i_work,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output pead_pkg::t_work o_head
);

    pead_pkg::t_work                r_mem [pead_pkg::QueueDepth];
    logic [pead_pkg::QPtrW-1:0]     r_wr;
    logic [pead_pkg::QPtrW-1:0]     r_rd;
    logic [pead_pkg::QPtrW:0]       r_count;
    logic                           w_do_pop;

    assign o_full   = (r_count == (pead_pkg::QPtrW+1)'(pead_pkg::QueueDepth));
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + pead_pkg::QPtrW'(1);
            end
            if (w_do_pop) begin
                r_rd <= r_rd + pead_pkg::QPtrW'(1);
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + (pead_pkg::QPtrW+1)'(1);
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - (pead_pkg::QPtrW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// ===== src/pead_back.sv =====
// back stage: computes the sweep offset, emits one or two output vertices per entry
// depends on pead_pkg

module pead_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pead_pkg::t_cfg      i_cfg,
    input  logic                i_head_valid,
    input  pead_pkg::t_work     i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output pead_pkg::t_out_item o_data
);

    logic signed [pead_pkg::ProdW-1:0]   r_prod_x;
    logic signed [pead_pkg::ProdW-1:0]   r_prod_y;
    logic signed [pead_pkg::ShiftW-1:0]  r_tx;
    logic signed [pead_pkg::ShiftW-1:0]  r_ty;
    logic signed [pead_pkg::ProdW:0]     w_rx;
    logic signed [pead_pkg::ProdW:0]     w_ry;
    logic signed [pead_pkg::CoordW-1:0]  w_mx;
    logic signed [pead_pkg::CoordW-1:0]  w_my;
    logic signed [pead_pkg::NormW-1:0]   w_ccw_x;
    logic signed [pead_pkg::NormW-1:0]   w_ccw_y;
    logic signed [pead_pkg::NormW-1:0]   w_cw_x;
    logic signed [pead_pkg::NormW-1:0]   w_cw_y;
    logic                                r_ov;
    logic                                r_phase;
    logic                                n_phase;
    pead_pkg::t_out_item                 r_out;
    pead_pkg::t_out_item                 n_out;
    logic                                w_load;
    logic                                w_two;

    // offset = round(dir * distance / 2^14), ties toward plus infinity
    assign w_rx = (pead_pkg::ProdW+1)'(r_prod_x) + (pead_pkg::ProdW+1)'(8192);
    assign w_ry = (pead_pkg::ProdW+1)'(r_prod_y) + (pead_pkg::ProdW+1)'(8192);

    always_ff @(posedge i_clk) begin
        r_prod_x <= i_cfg.dir_x * i_cfg.move_distance;
        r_prod_y <= i_cfg.dir_y * i_cfg.move_distance;
        r_tx     <= pead_pkg::ShiftW'(w_rx >>> pead_pkg::FracShift);
        r_ty     <= pead_pkg::ShiftW'(w_ry >>> pead_pkg::FracShift);
    end

    assign w_mx = pead_pkg::sat_coord(pead_pkg::SumW'(i_head.vertex_x) + pead_pkg::SumW'(r_tx));
    assign w_my = pead_pkg::sat_coord(pead_pkg::SumW'(i_head.vertex_y) + pead_pkg::SumW'(r_ty));
    assign w_ccw_x = -i_cfg.dir_y;
    assign w_ccw_y = i_cfg.dir_x;
    assign w_cw_x  = i_cfg.dir_y;
    assign w_cw_y  = -i_cfg.dir_x;

    assign w_load  = i_head_valid && (!r_ov || !i_stall);
    assign w_two   = (i_head.kind == pead_pkg::KIND_FIRST) || (i_head.kind == pead_pkg::KIND_LAST);
    assign o_pop   = w_load && (!w_two || r_phase);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        n_out.out_x        = i_head.vertex_x;
        n_out.out_y        = i_head.vertex_y;
        n_out.out_normal_x = i_head.normal_x;
        n_out.out_normal_y = i_head.normal_y;
        n_out.run_end      = 1'b1;
        n_out.polygon_end  = i_head.final_vertex;
        n_phase            = 1'b0;
        case (i_head.kind)
            pead_pkg::KIND_KEEP: begin
            end
            pead_pkg::KIND_MOVE: begin
                n_out.out_x = w_mx;
                n_out.out_y = w_my;
            end
            pead_pkg::KIND_FIRST: begin
                if (!r_phase) begin
                    n_out.out_normal_x = w_ccw_x;
                    n_out.out_normal_y = w_ccw_y;
                    n_out.run_end      = 1'b0;
                    n_out.polygon_end  = 1'b0;
                    n_phase            = 1'b1;
                end else begin
                    n_out.out_x = w_mx;
                    n_out.out_y = w_my;
                end
            end
            pead_pkg::KIND_LAST: begin
                if (!r_phase) begin
                    n_out.out_x        = w_mx;
                    n_out.out_y        = w_my;
                    n_out.out_normal_x = w_cw_x;
                    n_out.out_normal_y = w_cw_y;
                    n_out.run_end      = 1'b0;
                    n_out.polygon_end  = 1'b0;
                    n_phase            = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!i_cfg.normals_present) begin
            n_out.out_normal_x = '0;
            n_out.out_normal_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_phase <= 1'b0;
        end else if (w_load) begin
            r_ov    <= 1'b1;
            r_phase <= n_phase;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // second half of a duplicated vertex is still owed
    a_phase_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_head_valid)
        else $error("phase set with empty queue");

    a_phase_two_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_head.kind == pead_pkg::KIND_FIRST || i_head.kind == pead_pkg::KIND_LAST))
        else $error("phase set on single-result entry");

    a_open_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.run_end) |-> r_phase)
        else $error("run left open without pending second result");

    a_poly_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.polygon_end) |-> r_out.run_end)
        else $error("polygon end on non-final result of a vertex");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for polygon_extend_along_direction
// drives vertex streams and register writes, predicts each swept vertex in a local model
// depends on pead_pkg and the polygon_extend_along_direction rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CoordMax      = 64'sd2147483647;
    localparam longint CoordMin      = -64'sd2147483648;
    localparam int     HoldCycles    = 200;
    localparam int     WatchdogLimit = 3000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          blk_stall;
    pead_pkg::t_in_item            in_data;
    logic                          out_valid;
    logic                          rx_stall;
    pead_pkg::t_out_item           out_data;
    logic                          cfg_we;
    logic [pead_pkg::CfgIdxW-1:0]  cfg_idx;
    logic [pead_pkg::CfgDataW-1:0] cfg_data;

    pead_pkg::t_cfg                sweep_cfg;
    logic [pead_pkg::RangeW-1:0]   vtx_idx;
    pead_pkg::t_out_item           pending[$];

    bit steady;
    bit hold_req;
    int errors;
    int quiet_cycles;
    int vertices_sent;
    int polygons_closed;
    int results_checked;
    int doubled_vertices;
    int settings_count;

    polygon_extend_along_direction dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (blk_stall),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_stall    (rx_stall),
        .o_data     (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic pead_pkg::t_cfg make_cfg(
        input logic signed [pead_pkg::NormW-1:0]  dx,
        input logic signed [pead_pkg::NormW-1:0]  dy,
        input logic signed [pead_pkg::CoordW-1:0] distance,
        input logic [pead_pkg::RangeW-1:0]        first,
        input logic [pead_pkg::RangeW-1:0]        last,
        input logic ff, input logic lf, input logic np);
        pead_pkg::t_cfg c;
        c.dir_x           = dx;
        c.dir_y           = dy;
        c.move_distance   = distance;
        c.range_first     = first;
        c.range_last      = last;
        c.first_edge_flat = ff;
        c.last_edge_flat  = lf;
        c.normals_present = np;
        return c;
    endfunction

    function automatic pead_pkg::t_in_item mk_vertex(
        input logic signed [pead_pkg::CoordW-1:0] x,
        input logic signed [pead_pkg::CoordW-1:0] y,
        input logic signed [pead_pkg::NormW-1:0]  nx,
        input logic signed [pead_pkg::NormW-1:0]  ny,
        input logic fin);
        pead_pkg::t_in_item v;
        v.vertex_x     = x;
        v.vertex_y     = y;
        v.normal_x     = nx;
        v.normal_y     = ny;
        v.final_vertex = fin;
        return v;
    endfunction

    // mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [pead_pkg::NormW-1:0] pick_dir();
        case ($urandom_range(0, 6))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return '0;
            3: return 16'sh8000;
            4: return 16'sh7fff;
            5: return pead_pkg::NormW'($urandom);
            default: return pead_pkg::NormW'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    function automatic logic signed [pead_pkg::CoordW-1:0] pick_dist();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0000;
            3: return pead_pkg::CoordW'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [pead_pkg::RangeW-1:0] pick_range();
        if ($urandom_range(0, 9) == 0) begin
            return pead_pkg::RangeW'($urandom_range(0, 255));
        end
        return pead_pkg::RangeW'($urandom_range(0, 11));
    endfunction

    function automatic logic signed [pead_pkg::CoordW-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return pead_pkg::CoordW'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            1: return 32'sh7fff_0000 + pead_pkg::CoordW'($urandom_range(0, 32'hffff));
            2: return 32'sh8000_0000 + pead_pkg::CoordW'($urandom_range(0, 32'hffff));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [pead_pkg::NormW-1:0] pick_normal();
        if ($urandom_range(0, 1) == 0) begin
            return pead_pkg::NormW'($urandom);
        end
        return pead_pkg::NormW'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    function automatic pead_pkg::t_in_item random_vertex(input logic fin);
        return mk_vertex(pick_coord(), pick_coord(), pick_normal(), pick_normal(), fin);
    endfunction

    function automatic pead_pkg::t_cfg random_cfg();
        return make_cfg(pick_dir(), pick_dir(), pick_dist(), pick_range(), pick_range(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
    endfunction

    // offset along one axis: dir * distance / 2^14, nearest, ties toward +inf
    function automatic longint sweep_offset(input logic signed [pead_pkg::NormW-1:0] d);
        longint prod;
        prod = longint'(d) * longint'(sweep_cfg.move_distance) + 64'sd8192;
        return prod >>> pead_pkg::FracShift;
    endfunction

    function automatic logic signed [pead_pkg::CoordW-1:0] clamp_coord(input longint s);
        if (s > CoordMax) begin
            return CoordMax[pead_pkg::CoordW-1:0];
        end else if (s < CoordMin) begin
            return CoordMin[pead_pkg::CoordW-1:0];
        end
        return s[pead_pkg::CoordW-1:0];
    endfunction

    function automatic void predict_sweep(input pead_pkg::t_in_item v);
        pead_pkg::t_out_item kept;
        pead_pkg::t_out_item moved;
        pead_pkg::t_out_item extra;
        logic                in_range;
        kept = '0;
        kept.out_x = v.vertex_x;
        kept.out_y = v.vertex_y;
        if (sweep_cfg.normals_present) begin
            kept.out_normal_x = v.normal_x;
            kept.out_normal_y = v.normal_y;
        end
        kept.run_end     = 1'b1;
        kept.polygon_end = v.final_vertex;
        moved = kept;
        moved.out_x = clamp_coord(longint'(v.vertex_x) + sweep_offset(sweep_cfg.dir_x));
        moved.out_y = clamp_coord(longint'(v.vertex_y) + sweep_offset(sweep_cfg.dir_y));
        if (vtx_idx == sweep_cfg.range_first && !sweep_cfg.first_edge_flat) begin
            extra = kept;
            extra.run_end     = 1'b0;
            extra.polygon_end = 1'b0;
            if (sweep_cfg.normals_present) begin
                extra.out_normal_x = -sweep_cfg.dir_y;
                extra.out_normal_y = sweep_cfg.dir_x;
            end
            pending.push_back(extra);
            pending.push_back(moved);
            doubled_vertices++;
        end else if (vtx_idx == sweep_cfg.range_last && !sweep_cfg.last_edge_flat) begin
            extra = moved;
            extra.run_end     = 1'b0;
            extra.polygon_end = 1'b0;
            if (sweep_cfg.normals_present) begin
                extra.out_normal_x = sweep_cfg.dir_y;
                extra.out_normal_y = -sweep_cfg.dir_x;
            end
            pending.push_back(extra);
            pending.push_back(kept);
            doubled_vertices++;
        end else begin
            if (sweep_cfg.range_first > sweep_cfg.range_last) begin
                in_range = (vtx_idx <= sweep_cfg.range_last) ||
                           (vtx_idx >= sweep_cfg.range_first);
            end else begin
                in_range = (vtx_idx >= sweep_cfg.range_first) &&
                           (vtx_idx <= sweep_cfg.range_last);
            end
            pending.push_back(in_range ? moved : kept);
        end
        vtx_idx = v.final_vertex ? '0 : vtx_idx + pead_pkg::RangeW'(1);
        vertices_sent++;
        if (v.final_vertex) begin
            polygons_closed++;
        end
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [pead_pkg::CoordW-1:0] want,
                                        input logic signed [pead_pkg::CoordW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input pead_pkg::t_out_item got);
        pead_pkg::t_out_item want;
        if (pending.size() == 0) begin
            $error("result with no vertex waiting: x %0d y %0d", got.out_x, got.out_y);
            errors++;
            return;
        end
        want = pending.pop_front();
        results_checked++;
        check_field("out_x", want.out_x, got.out_x);
        check_field("out_y", want.out_y, got.out_y);
        check_field("out_normal_x", pead_pkg::CoordW'(want.out_normal_x),
                    pead_pkg::CoordW'(got.out_normal_x));
        check_field("out_normal_y", pead_pkg::CoordW'(want.out_normal_y),
                    pead_pkg::CoordW'(got.out_normal_y));
        check_field("run_end", pead_pkg::CoordW'(want.run_end),
                    pead_pkg::CoordW'(got.run_end));
        check_field("polygon_end", pead_pkg::CoordW'(want.polygon_end),
                    pead_pkg::CoordW'(got.polygon_end));
    endfunction

    // monitor: predicts on each accepted vertex, checks each accepted result
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !blk_stall) begin
                predict_sweep(in_data);
            end
            if (out_valid && !rx_stall) begin
                check_result(out_data);
            end
        end
        if ((in_valid && !blk_stall) || (out_valid && !rx_stall) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin : receiver
        rx_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                rx_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                rx_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (steady || $urandom_range(0, 2) != 0) begin
                rx_stall <= 1'b0;
                if (!steady) begin
                    repeat (idle_len()) @(posedge clk);
                end
            end else begin
                rx_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WatchdogLimit) @(posedge clk);
        $error("no transaction for %0d cycles", WatchdogLimit);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_vertex(input pead_pkg::t_in_item v);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do @(posedge clk); while (blk_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input pead_pkg::t_cfg_reg sel,
                             input logic [pead_pkg::CfgDataW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= sel;
        cfg_data <= val;
        @(posedge clk);
        case (sel)
            pead_pkg::CFG_DIR_X:
                sweep_cfg.dir_x = val[pead_pkg::NormW-1:0];
            pead_pkg::CFG_DIR_Y:
                sweep_cfg.dir_y = val[pead_pkg::NormW-1:0];
            pead_pkg::CFG_MOVE_DISTANCE:
                sweep_cfg.move_distance = val[pead_pkg::CoordW-1:0];
            pead_pkg::CFG_RANGE_FIRST:
                sweep_cfg.range_first = val[pead_pkg::RangeW-1:0];
            pead_pkg::CFG_RANGE_LAST:
                sweep_cfg.range_last = val[pead_pkg::RangeW-1:0];
            pead_pkg::CFG_FIRST_EDGE_FLAT:
                sweep_cfg.first_edge_flat = val[0];
            pead_pkg::CFG_LAST_EDGE_FLAT:
                sweep_cfg.last_edge_flat = val[0];
            pead_pkg::CFG_NORMALS_PRESENT:
                sweep_cfg.normals_present = val[0];
            default: ;
        endcase
    endtask

    // block must be idle; the offset settles through the product and offset registers
    task automatic apply_settings(input pead_pkg::t_cfg c);
        write_reg(pead_pkg::CFG_DIR_X, pead_pkg::CfgDataW'(c.dir_x));
        write_reg(pead_pkg::CFG_DIR_Y, pead_pkg::CfgDataW'(c.dir_y));
        write_reg(pead_pkg::CFG_MOVE_DISTANCE, pead_pkg::CfgDataW'(c.move_distance));
        write_reg(pead_pkg::CFG_RANGE_FIRST, pead_pkg::CfgDataW'(c.range_first));
        write_reg(pead_pkg::CFG_RANGE_LAST, pead_pkg::CfgDataW'(c.range_last));
        write_reg(pead_pkg::CFG_FIRST_EDGE_FLAT, pead_pkg::CfgDataW'(c.first_edge_flat));
        write_reg(pead_pkg::CFG_LAST_EDGE_FLAT, pead_pkg::CfgDataW'(c.last_edge_flat));
        write_reg(pead_pkg::CFG_NORMALS_PRESENT, pead_pkg::CfgDataW'(c.normals_present));
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
        settings_count++;
    endtask

    task automatic test_directed();
        // reset settings: first and last at index 0, zero distance
        send_vertex(mk_vertex(32'sh7fff_ffff, 32'sh8000_0000, -16'sd16384, 16'sd16384, 1'b0));
        send_vertex(mk_vertex(32'sh8000_0000, 32'sh7fff_ffff, 16'sh7fff, 16'sh8000, 1'b0));
        send_vertex(mk_vertex(32'sh0001_0000, -32'sd1, '0, '0, 1'b1));
        wait_drained();

        // saturating sweep with both duplicates and normals
        apply_settings(make_cfg(-16'sd16384, 16'sd16384, 32'sh7fff_ffff, 8'd1, 8'd2,
                                1'b0, 1'b0, 1'b1));
        send_vertex(mk_vertex('0, '0, 16'sd16384, '0, 1'b0));
        send_vertex(mk_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, -16'sd16384, -16'sd16384, 1'b0));
        send_vertex(mk_vertex(32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh7fff, 1'b0));
        send_vertex(mk_vertex(32'sd12345, -32'sd12345, '0, 16'sd16384, 1'b1));
        wait_drained();

        // wrapping range, both edges flat, rotation of -32768
        apply_settings(make_cfg(16'sh8000, 16'sh7fff, 32'sh8000_0000, 8'd3, 8'd0,
                                1'b1, 1'b1, 1'b1));
        send_vertex(mk_vertex(32'sh8000_0000, 32'sh7fff_ffff, 16'sd100, -16'sd100, 1'b0));
        send_vertex(mk_vertex(32'sd1, 32'sd2, 16'sd16384, '0, 1'b0));
        send_vertex(mk_vertex(-32'sd1, -32'sd2, '0, -16'sd16384, 1'b0));
        send_vertex(mk_vertex(32'sh7fff_ffff, 32'sh8000_0000, 16'sh8000, 16'sh8000, 1'b0));
        send_vertex(mk_vertex(32'sh0100_0000, -32'sh0100_0000, 16'sh7fff, 16'sh7fff, 1'b1));
        wait_drained();

        // first equals last, first edge flat: last duplicate wins; tie rounds up
        apply_settings(make_cfg(16'sd8192, -16'sd8192, 32'sd1, 8'd2, 8'd2,
                                1'b1, 1'b0, 1'b1));
        send_vertex(mk_vertex('0, '0, 16'sd1, 16'sd2, 1'b0));
        send_vertex(mk_vertex(32'sd7, 32'sd7, 16'sd3, 16'sd4, 1'b0));
        send_vertex(mk_vertex(-32'sd7, -32'sd7, 16'sd5, 16'sd6, 1'b1));
        wait_drained();

        // first equals last, neither flat: first duplicate wins
        apply_settings(make_cfg(16'sd8192, -16'sd8192, -32'sd1, 8'd1, 8'd1,
                                1'b0, 1'b0, 1'b0));
        send_vertex(mk_vertex(32'sd10, 32'sd20, 16'sd1, 16'sd1, 1'b0));
        send_vertex(mk_vertex(32'sd30, 32'sd40, 16'sd1, 16'sd1, 1'b0));
        send_vertex(mk_vertex(32'sd50, 32'sd60, 16'sd1, 16'sd1, 1'b1));
        wait_drained();

        // range past the end of the polygon never matches
        apply_settings(make_cfg(16'sd11585, 16'sd11585, 32'sh0003_0000, 8'd200, 8'd250,
                                1'b0, 1'b0, 1'b1));
        send_vertex(mk_vertex(32'sd5, 32'sd5, 16'sd9, 16'sd9, 1'b0));
        send_vertex(mk_vertex(32'sd6, 32'sd6, 16'sd9, 16'sd9, 1'b1));
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        apply_settings(random_cfg());
        steady   = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++) begin
            send_vertex(random_vertex(k % 7 == 6));
        end
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_polygons();
        pead_pkg::t_in_item v;
        int                 phase;
        int                 len;
        int                 k;
        int                 budget;
        for (phase = 0; phase < 6; phase++) begin
            apply_settings(random_cfg());
            steady = (phase == 2);
            budget = 0;
            while (budget < 65) begin
                len = $urandom_range(3, 12);
                for (k = 0; k < len; k++) begin
                    v = random_vertex(k == len - 1);
                    // broken polygons now and then
                    if ($urandom_range(0, 19) == 0) begin
                        v.final_vertex = 1'($urandom_range(0, 1));
                    end
                    send_vertex(v);
                    budget++;
                    if ($urandom_range(0, 59) == 0) begin
                        wait_drained();
                    end
                end
            end
            steady = 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_index_wrap();
        pead_pkg::t_cfg c;
        int             k;
        c = random_cfg();
        c.range_first = 8'd254;
        c.range_last  = 8'd3;
        apply_settings(c);
        for (k = 0; k < 270; k++) begin
            send_vertex(random_vertex(k == 269));
        end
        wait_drained();
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        steady   = 1'b0;
        hold_req = 1'b0;
        sweep_cfg = make_cfg(16'sd16384, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        vtx_idx  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_polygons();
        test_index_wrap();

        wait_drained();
        repeat (6) @(posedge clk);
        if (pending.size() != 0) begin
            $error("%0d results never arrived", pending.size());
            errors++;
        end
        $display("summary: %0d vertices in %0d closed polygons, %0d results checked, %0d doubled",
                 vertices_sent, polygons_closed, results_checked, doubled_vertices);
        $display("summary: %0d register settings, incl. long output hold and index wrap",
                 settings_count);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
